FILE: rtl/core/depth_limited_reach_counter_assert.svh
// assertion macros for the reach counter
`ifndef DEPTH_LIMITED_REACH_COUNTER_ASSERT_SVH
`define DEPTH_LIMITED_REACH_COUNTER_ASSERT_SVH
// implication checked on every clock edge outside reset
`define DLRC_ASSERT_IMPL(lbl, clk_s, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// condition that must hold on every clock edge outside reset
`define DLRC_ASSERT_ALWAYS(lbl, clk_s, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (cond)) else $error(msg);
`endif

FILE: rtl/core/dlrc_pkg.sv
// package: widths, codes and defaults for the reach counter
`timescale 1ns / 1ps
package dlrc_pkg;
	localparam int ID_W = 10;
	localparam int LAYER_W = 4;
	localparam int COUNT_W = 10;
	localparam int STATUS_W = 2;
	localparam int NODES_DEF = 1024;
	localparam int MAX_FANS_DEF = 64;
	localparam logic [ID_W-1:0] USER_COUNT_RST = 10'd1023;
	localparam logic [LAYER_W-1:0] MAX_LAYERS_RST = 4'd3;
	localparam logic [0:0] CFG_USER_COUNT = 1'b0;
	localparam logic [0:0] CFG_MAX_LAYERS = 1'b1;
	localparam logic [0:0] ACT_ADD = 1'b0;
	localparam logic [0:0] ACT_QUERY = 1'b1;
	localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_ID = 2'd2;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 10'd1023;
endpackage

FILE: rtl/core/dlrc_item_if.sv
// valid/ready channel carrying an input item
`timescale 1ns / 1ps
interface dlrc_item_if;
	logic valid;
	logic ready;
	logic action;
	logic [dlrc_pkg::ID_W-1:0] user_id;
	logic [dlrc_pkg::ID_W-1:0] followed_id;
	modport source (output valid, action, user_id, followed_id, input ready);
	modport sink (input valid, action, user_id, followed_id, output ready);
endinterface

FILE: rtl/core/dlrc_result_if.sv
// valid/ready channel carrying a result item
`timescale 1ns / 1ps
interface dlrc_result_if;
	logic valid;
	logic ready;
	logic [dlrc_pkg::COUNT_W-1:0] reach_count;
	logic [dlrc_pkg::STATUS_W-1:0] status;
	modport source (output valid, reach_count, status, input ready);
	modport sink (input valid, reach_count, status, output ready);
endinterface

FILE: rtl/core/dlrc_ram.sv
// generic single-port-write, one-read synchronous ram
`timescale 1ns / 1ps
module dlrc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: rtl/core/depth_limited_reach_counter.sv
// top level: follower graph store and depth-limited breadth-first reach counter
//
//  channel   dir   beat contents
//  in_ch     sink  action, user_id, followed_id
//  out_ch    src   reach_count, status
//  cfg       in    cfg_we, cfg_index, cfg_wdata
//
// an add reads fan_count in S_ADD_RD, then writes in S_ADD_WR unless full, and answers;
// a rejected id answers in the cycle after the beat.
// a query first sweeps the visited map, then walks the frontier: each dequeued
// node passes S_POP, S_NODE and S_CNT, each fan_list entry S_FAN and both S_VIS phases.
// arst_n clears control state and the fan_count clearing pass; after reset the
// block sweeps fan_count to zero before taking its first beat.
// a result beat waits in an output register; the next item is taken once it leaves.
`timescale 1ns / 1ps
module depth_limited_reach_counter #(
	parameter int NODES = dlrc_pkg::NODES_DEF,
	parameter int MAX_FANS = dlrc_pkg::MAX_FANS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [0:0]        cfg_index,
	input  logic [dlrc_pkg::ID_W-1:0] cfg_wdata,
	dlrc_item_if.sink         in_ch,
	dlrc_result_if.source     out_ch
);
	`include "depth_limited_reach_counter_assert.svh"

	localparam int NW = $clog2(NODES);
	localparam int FW = $clog2(MAX_FANS + 1);   // fan count width, holds MAX_FANS
	localparam int KW = (MAX_FANS > 1) ? $clog2(MAX_FANS) : 1;
	localparam int LW = NW + KW;                 // fan_list address width
	localparam int QW = dlrc_pkg::LAYER_W + dlrc_pkg::ID_W;
	localparam logic [FW-1:0] FULL = FW'(MAX_FANS);
	localparam logic [NW:0] NODES_V = (NW+1)'(NODES);
	localparam logic [31:0] NODES_U = 32'(NODES);

	typedef enum logic [10:0] {
		S_INIT   = 11'b00000000001,  // fan_count clearing pass
		S_IDLE   = 11'b00000000010,
		S_ADD_RD = 11'b00000000100,  // fan_count read in flight
		S_ADD_WR = 11'b00000001000,
		S_CLR    = 11'b00000010000,  // visited sweep
		S_POP    = 11'b00000100000,  // frontier read issued
		S_NODE   = 11'b00001000000,  // frontier data back, check layer, read count
		S_CNT    = 11'b00010000000,  // fan count back
		S_FAN    = 11'b00100000000,  // fan_list read issued
		S_VIS    = 11'b01000000000,  // visited read issued for a fan
		S_DONE   = 11'b10000000000
	} state_t;

	state_t state_q;
	logic [dlrc_pkg::ID_W-1:0] user_count_q;
	logic [dlrc_pkg::LAYER_W-1:0] max_layers_q;
	logic [NW:0] sweep_q;
	logic [dlrc_pkg::ID_W-1:0] uid_q, fid_q;
	logic [NW:0] head_q, tail_q;
	logic [dlrc_pkg::LAYER_W-1:0] layer_q;
	logic [NW-1:0] node_q;
	logic [FW-1:0] n_q, k_q;
	logic [dlrc_pkg::ID_W-1:0] fan_q;
	logic [NW:0] reached_q;
	logic out_valid_q;
	logic [dlrc_pkg::COUNT_W-1:0] out_count_q;
	logic [dlrc_pkg::STATUS_W-1:0] out_status_q;
	// S_VIS has two phases: latch fan and issue visited read, then decide
	logic vis_phase_q;

	// memory ports
	logic fc_we; logic [NW-1:0] fc_wa, fc_ra; logic [FW-1:0] fc_wd, fc_rd;
	logic fl_we; logic [LW-1:0] fl_wa, fl_ra; logic [dlrc_pkg::ID_W-1:0] fl_wd, fl_rd;
	logic vi_we; logic [NW-1:0] vi_wa, vi_ra; logic [0:0] vi_wd, vi_rd;
	logic fr_we; logic [NW-1:0] fr_wa, fr_ra; logic [QW-1:0] fr_wd, fr_rd;

	dlrc_ram #(.WIDTH(FW), .DEPTH(NODES)) u_fan_count (.clk, .we(fc_we), .waddr(fc_wa),
		.wdata(fc_wd), .raddr(fc_ra), .rdata(fc_rd));
	dlrc_ram #(.WIDTH(dlrc_pkg::ID_W), .DEPTH(1 << LW)) u_fan_list (.clk,
		.we(fl_we), .waddr(fl_wa), .wdata(fl_wd), .raddr(fl_ra), .rdata(fl_rd));
	dlrc_ram #(.WIDTH(1), .DEPTH(NODES)) u_visited (.clk, .we(vi_we), .waddr(vi_wa),
		.wdata(vi_wd), .raddr(vi_ra), .rdata(vi_rd));
	dlrc_ram #(.WIDTH(QW), .DEPTH(NODES)) u_frontier (.clk, .we(fr_we), .waddr(fr_wa),
		.wdata(fr_wd), .raddr(fr_ra), .rdata(fr_rd));

	// id check: 1..user_count and below NODES
	function automatic logic id_ok(input logic [dlrc_pkg::ID_W-1:0] id,
			input logic [dlrc_pkg::ID_W-1:0] uc);
		id_ok = (id != '0) && (id <= uc) && (32'(id) < NODES_U);
	endfunction

	logic accept;
	assign in_ch.ready = (state_q == S_IDLE) && !out_valid_q;
	assign accept = in_ch.valid && in_ch.ready;
	assign out_ch.valid = out_valid_q;
	assign out_ch.reach_count = out_count_q;
	assign out_ch.status = out_status_q;

	logic [dlrc_pkg::ID_W-1:0] fr_node;
	logic [dlrc_pkg::LAYER_W-1:0] fr_layer;
	assign fr_node = fr_rd[dlrc_pkg::ID_W-1:0];
	assign fr_layer = fr_rd[QW-1:dlrc_pkg::ID_W];

	// memory addressing per state
	always_comb begin
		fc_we = 1'b0; fc_wa = NW'(fid_q); fc_wd = fc_rd + FW'(1);
		fc_ra = NW'(fid_q);
		fl_we = 1'b0; fl_wa = {NW'(fid_q), fc_rd[KW-1:0]}; fl_wd = uid_q;
		fl_ra = {node_q, k_q[KW-1:0]};
		vi_we = 1'b0; vi_wa = NW'(fan_q); vi_wd = 1'b1;
		vi_ra = NW'(fl_rd);
		fr_we = 1'b0; fr_wa = tail_q[NW-1:0];
		fr_wd = {layer_q + dlrc_pkg::LAYER_W'(1), fan_q};
		fr_ra = head_q[NW-1:0];
		case (state_q)
			S_INIT: begin
				fc_we = 1'b1; fc_wa = sweep_q[NW-1:0]; fc_wd = '0;
			end
			S_ADD_WR: begin
				if (fc_rd < FULL) begin
					fc_we = 1'b1; fl_we = 1'b1;
				end
			end
			S_CLR: begin
				vi_we = 1'b1; vi_wa = sweep_q[NW-1:0]; vi_wd = 1'b0;
				if (sweep_q == NODES_V) begin
					vi_wa = NW'(uid_q); vi_wd = 1'b1;
					fr_we = 1'b1; fr_wa = '0; fr_wd = {{dlrc_pkg::LAYER_W{1'b0}}, uid_q};
				end
			end
			S_NODE: fc_ra = NW'(fr_node);
			S_VIS: begin
				// decide only once the visited bit for the latched fan is back
				if (vis_phase_q && !vi_rd[0] && (32'(fan_q) < NODES_U)) begin
					vi_we = 1'b1;
					fr_we = tail_q < NODES_V;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			sweep_q <= '0;
			user_count_q <= dlrc_pkg::USER_COUNT_RST;
			max_layers_q <= dlrc_pkg::MAX_LAYERS_RST;
			out_valid_q <= 1'b0;
			head_q <= '0;
			tail_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					dlrc_pkg::CFG_USER_COUNT: user_count_q <= cfg_wdata;
					dlrc_pkg::CFG_MAX_LAYERS: max_layers_q <= cfg_wdata[dlrc_pkg::LAYER_W-1:0];
					default: ;
				endcase
			end
			if (out_valid_q && out_ch.ready) out_valid_q <= 1'b0;
			case (state_q)
				S_INIT: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == NODES_V - 1'b1) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept) begin
						uid_q <= in_ch.user_id;
						fid_q <= in_ch.followed_id;
						out_count_q <= '0;
						if (in_ch.action == dlrc_pkg::ACT_ADD) begin
							if (id_ok(in_ch.user_id, user_count_q) &&
									id_ok(in_ch.followed_id, user_count_q)) begin
								state_q <= S_ADD_RD;
							end else begin
								out_status_q <= dlrc_pkg::ST_BAD_ID;
								out_valid_q <= 1'b1;
							end
						end else if (id_ok(in_ch.user_id, user_count_q)) begin
							state_q <= S_CLR;
							sweep_q <= '0;
						end else begin
							out_status_q <= dlrc_pkg::ST_BAD_ID;
							out_valid_q <= 1'b1;
						end
					end
				end
				S_ADD_RD: state_q <= S_ADD_WR;
				S_ADD_WR: begin
					out_status_q <= (fc_rd < FULL) ? dlrc_pkg::ST_OK : dlrc_pkg::ST_FULL;
					out_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				S_CLR: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == NODES_V) begin
						head_q <= '0;
						tail_q <= (NW+1)'(1);
						reached_q <= '0;
						state_q <= S_POP;
					end
				end
				S_POP: state_q <= (head_q < tail_q) ? S_NODE : S_DONE;
				S_NODE: begin
					// frontier entry back; layers at the limit end the walk
					if (fr_layer >= max_layers_q) begin
						state_q <= S_DONE;
					end else begin
						head_q <= head_q + 1'b1;
						layer_q <= fr_layer;
						node_q <= NW'(fr_node);
						state_q <= (32'(fr_node) < NODES_U) ? S_CNT : S_POP;
					end
				end
				S_CNT: begin
					n_q <= (fc_rd > FULL) ? FULL : fc_rd;
					k_q <= '0;
					state_q <= (fc_rd == '0) ? S_POP : S_FAN;
				end
				S_FAN: begin
					// fan_list read in flight; next cycle data arrives, visited read follows
					k_q <= k_q + 1'b1;
					state_q <= S_VIS;
				end
				S_VIS: begin
					if (!vis_phase_q) begin
						fan_q <= fl_rd;
					end else begin
						// visited decision uses the fan latched in the first phase
						if (!vi_rd[0] && (32'(fan_q) < NODES_U)) begin
							if (tail_q < NODES_V) tail_q <= tail_q + 1'b1;
							reached_q <= reached_q + 1'b1;
						end
						state_q <= (k_q < n_q) ? S_FAN : S_POP;
					end
				end
				S_DONE: begin
					out_status_q <= dlrc_pkg::ST_OK;
					out_count_q <= (reached_q > (NW+1)'(dlrc_pkg::COUNT_MAX))
						? dlrc_pkg::COUNT_MAX : dlrc_pkg::COUNT_W'(reached_q);
					out_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vis_phase_q <= 1'b0;
		else if (state_q == S_VIS) vis_phase_q <= !vis_phase_q;
		else vis_phase_q <= 1'b0;
	end

	`DLRC_ASSERT_IMPL(a_no_accept_busy, clk, arst_n, state_q != S_IDLE, !in_ch.ready,
		"item taken while busy")
	`DLRC_ASSERT_ALWAYS(a_head_le_tail, clk, arst_n, head_q <= tail_q, "frontier underrun")
	`DLRC_ASSERT_IMPL(a_tail_bound, clk, arst_n, 1'b1, tail_q <= NODES_V, "frontier overrun")
endmodule
